>>> rtl/tls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_pkg: shared types, constants and character classes
// Widths, character codes and the operator pair table for the token scanner.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int MAX_TOKEN_LENGTH = 255;
  localparam int CHAR_W           = 8;
  localparam int LEN_W            = 8;
  localparam int CNT_W            = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int LEN_MAX          = (1 << LEN_W) - 1;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Character codes
  localparam char_t CH_NONE   = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_F      = 8'h66;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_HIGH   = 8'h80;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_PCT    = 8'h25;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_EQ     = 8'h3D;
  localparam char_t CH_BANG   = 8'h21;
  localparam char_t CH_AMP    = 8'h26;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_SLASH  = 8'h2F;

  function automatic logic is_single_punct(input char_t c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COLON) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
           (c == CH_RBRACK) || (c == CH_CARET) || (c == CH_PCT) ||
           (c == CH_COMMA);
  endfunction

  function automatic logic is_pair_starter(input char_t c);
    return (c == CH_STAR) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) ||
           (c == CH_BANG) || (c == CH_AMP) || (c == CH_PLUS) ||
           (c == CH_MINUS) || (c == CH_SLASH);
  endfunction

  function automatic logic pair_matches(input char_t first, input char_t second);
    logic m;
    case (first)
      CH_STAR, CH_LT, CH_GT, CH_EQ, CH_BANG: m = (second == CH_EQ);
      CH_AMP:   m = (second == CH_AMP);
      CH_PLUS:  m = (second == CH_EQ) || (second == CH_PLUS);
      CH_MINUS: m = (second == CH_EQ) || (second == CH_MINUS);
      CH_SLASH: m = (second == CH_SLASH) || (second == CH_EQ);
      default:  m = 1'b0;
    endcase
    return m;
  endfunction

  // Reported length is capped at what the length field can hold.
  function automatic len_t cap_len(input cnt_t n);
    len_t r;
    if ({{(32-CNT_W){1'b0}}, n} > LEN_MAX) r = LEN_W'(LEN_MAX);
    else                                   r = LEN_W'(n);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tls_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_if: valid/ready channels of the token scanner
// Character input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tls_in_if;
  import tls_pkg::*;
  logic  valid;
  logic  ready;
  logic  start_req;
  char_t character;
  modport source (output valid, output start_req, output character, input ready);
  modport sink   (input valid, input start_req, input character, output ready);
endinterface

interface tls_out_if;
  import tls_pkg::*;
  logic valid;
  logic ready;
  len_t token_length;
  logic length_saturated;
  modport source (output valid, output token_length, output length_saturated,
                  input ready);
  modport sink   (input valid, input token_length, input length_saturated,
                  output ready);
endinterface

interface tls_cfg_if;
  logic valid;
  logic ready;
  logic keep_blanks;
  modport source (output valid, output keep_blanks, input ready);
  modport sink   (input valid, input keep_blanks, output ready);
endinterface
`default_nettype wire

>>> rtl/token_length_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// token_length_scanner: streaming token length finder
// Counts characters of script source and reports each token's length.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one source character per beat; start_req marks the first
//             character of a new scan and drops any scan in progress.
//   out_ch  : one beat per decided token: token_length and length_saturated.
//   cfg_ch  : keep_blanks write; always ready, write only while idle.
// Result path: a character that decides a token writes its result to the
//   result register (the skid entry if stalled). A two-character operator is
//   decided by the character after it, so the result follows that second beat.
// Throughput: one character per cycle while in_ch is ready. Classification,
//   the counter update and the result select all sit between the scan state and the result register.
// Stall: a result register plus one skid entry; in_ch stays ready while the
//   result register waits on a stalled receiver and drops ready only once
//   the skid entry is also full. Until then characters that decide nothing
//   flow freely.
// Reset: synchronous, active low. Clears the scan state (no scan running,
//   nothing pending), keep_blanks, and both output entries. No clearing pass.
// ----------------------------------------------------------------------------
module token_length_scanner (
  input  wire         clk,
  input  wire         rst_n,
  tls_in_if.sink      in_ch,
  tls_out_if.source   out_ch,
  tls_cfg_if.sink     cfg_ch
);
  import tls_pkg::*;

  // Scan state
  logic  keep_blanks_r;
  logic  scanning_r,  scanning_nxt;
  cnt_t  count_r,     count_nxt;
  logic  ovf_r,       ovf_nxt;
  logic  dot_r,       dot_nxt;
  logic  digits_r,    digits_nxt;
  char_t pend_r,      pend_nxt;

  // Output register and skid entry
  logic  out_v_r, skid_v_r;
  len_t  out_len_r, skid_len_r;
  logic  out_sat_r, skid_sat_r;

  logic  in_fire;
  logic  emit;
  cnt_t  emit_len;
  logic  emit_sat;
  logic  res_fire;

  assign cfg_ch.ready = 1'b1;
  // Stall only when both output entries hold results.
  assign in_ch.ready  = !skid_v_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign res_fire     = in_fire && emit;

  assign out_ch.valid            = out_v_r;
  assign out_ch.token_length     = out_len_r;
  assign out_ch.length_saturated = out_sat_r;

  // Per-character decision. Start_req first replaces the scan state, then
  // the character is classified against that (possibly fresh) state.
  always_comb begin
    char_t c;
    logic  s_scan, s_ovf, s_dot, s_digits, is_digit, f_hit;
    cnt_t  s_cnt;
    char_t s_pend;

    c        = in_ch.character;
    s_scan   = in_ch.start_req || scanning_r;
    s_cnt    = in_ch.start_req ? '0 : count_r;
    s_ovf    = in_ch.start_req ? 1'b0 : ovf_r;
    s_dot    = in_ch.start_req ? 1'b0 : dot_r;
    s_digits = in_ch.start_req ? 1'b1 : digits_r;
    s_pend   = in_ch.start_req ? CH_NONE : pend_r;

    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    scanning_nxt = s_scan;
    count_nxt    = s_cnt;
    ovf_nxt      = s_ovf;
    dot_nxt      = s_dot || (c == CH_DOT);
    // f_hit uses the digit flag from before this character
    f_hit        = (c == CH_F) && (s_cnt > CNT_W'(1)) && dot_nxt && s_digits;
    digits_nxt   = s_digits && (is_digit || (c == CH_DOT));
    pend_nxt     = s_pend;
    emit         = 1'b0;
    emit_len     = s_cnt;
    emit_sat     = s_ovf;

    if (!s_scan) begin
      // idle: character dropped
      emit = 1'b0;
    end else if (s_pend != CH_NONE) begin
      // lookahead decides a one- or two-character operator
      emit     = 1'b1;
      emit_len = pair_matches(s_pend, c) ? CNT_W'(2) : CNT_W'(1);
      emit_sat = 1'b0;
    end else if (f_hit) begin
      // float suffix: counted, then token ends
      emit = 1'b1;
      if (s_cnt < CNT_W'(MAX_TOKEN_LENGTH)) begin
        emit_len = s_cnt + CNT_W'(1);
      end else begin
        emit_sat = 1'b1;
      end
    end else if (keep_blanks_r && ((c == CH_TAB) || (c == CH_SPACE))) begin
      emit     = 1'b1;
      emit_len = (s_cnt == '0) ? CNT_W'(1) : s_cnt;
    end else if ((c <= CH_SPACE) || (c >= CH_HIGH) || (c == CH_SEMI)) begin
      emit = 1'b1;
    end else if (is_single_punct(c)) begin
      emit     = 1'b1;
      emit_len = (s_cnt == '0) ? CNT_W'(1) : s_cnt;
    end else if (is_pair_starter(c)) begin
      if (s_cnt == '0) begin
        pend_nxt = c;
      end else begin
        emit = 1'b1;
      end
    end else if ((c == CH_DOT) && (s_cnt == '0)) begin
      // leading dot is a token by itself
      emit     = 1'b1;
      emit_len = CNT_W'(1);
      emit_sat = 1'b0;
    end else if ((c == CH_DOT) && !s_digits) begin
      emit = 1'b1;
    end else begin
      if (s_cnt < CNT_W'(MAX_TOKEN_LENGTH)) begin
        count_nxt = s_cnt + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (emit) begin
      scanning_nxt = 1'b0;
      pend_nxt     = CH_NONE;
    end
  end

  // Configuration and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_blanks_r <= 1'b0;
      scanning_r    <= 1'b0;
      count_r       <= '0;
      ovf_r         <= 1'b0;
      dot_r         <= 1'b0;
      digits_r      <= 1'b1;
      pend_r        <= CH_NONE;
    end else begin
      if (cfg_ch.valid) begin
        keep_blanks_r <= cfg_ch.keep_blanks;
      end
      if (in_fire) begin
        scanning_r <= scanning_nxt;
        count_r    <= count_nxt;
        ovf_r      <= ovf_nxt;
        dot_r      <= dot_nxt;
        digits_r   <= digits_nxt;
        pend_r     <= pend_nxt;
      end
    end
  end

  // Result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (res_fire) begin
      if (out_v_r && !out_ch.ready) begin
        skid_v_r   <= 1'b1;
        skid_len_r <= cap_len(emit_len);
        skid_sat_r <= emit_sat;
      end else begin
        out_v_r   <= 1'b1;
        out_len_r <= cap_len(emit_len);
        out_sat_r <= emit_sat;
      end
    end else if (out_v_r && out_ch.ready) begin
      out_v_r   <= skid_v_r;
      out_len_r <= skid_len_r;
      out_sat_r <= skid_sat_r;
      skid_v_r  <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_checker: port-level checks for the token scanner
// Watches the channels of token_length_scanner; attached by bind.
// ----------------------------------------------------------------------------
module tls_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire [tls_pkg::LEN_W-1:0] out_token_length,
  input wire                out_length_saturated
);
  import tls_pkg::*;

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // results only appear after an accepted character
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat without a character");

  // input stalls only with a result waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with output empty");

  // saturation only happens at the length cap
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_saturated |-> out_token_length == LEN_W'(LEN_MAX))
    else $error("saturated beat below maximum length");

endmodule

bind token_length_scanner tls_checker u_tls_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_token_length     (out_ch.token_length),
  .out_length_saturated (out_ch.length_saturated)
);
`default_nettype wire

>>> sim/tb_token_length_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_length_scanner: self-checking bench for the token length scanner
// Streams script characters into the scanner under random sender bursts and
// receiver stalls. A scoreboard class predicts every token length from its
// own copy of the scan state and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_token_length_scanner;
  import tls_pkg::*;

  // One predicted or observed result beat.
  typedef struct packed {
    len_t length;
    logic saturated;
  } token_len_t;

  // --------------------------------------------------------------------------
  // Scoreboard: scan-state predictor plus the queue of token lengths that
  // are still owed by the block.
  // --------------------------------------------------------------------------
  class token_scoreboard;
    bit          keep_blanks;
    bit          scanning;
    cnt_t        count;
    bit          overflow;
    bit          seen_dot;
    bit          digits_only;
    char_t       pending_op;
    token_len_t  length_q[$];
    int unsigned errors;

    function new();
      keep_blanks = 1'b0;
      scanning    = 1'b0;
      count       = '0;
      overflow    = 1'b0;
      seen_dot    = 1'b0;
      digits_only = 1'b1;
      pending_op  = CH_NONE;
      errors      = 0;
    endfunction

    function void bump();
      if (count < cnt_t'(MAX_TOKEN_LENGTH)) count++;
      else overflow = 1'b1;
    endfunction

    function void close_token(int unsigned n, bit sat);
      token_len_t r;
      r.length    = (n > LEN_MAX) ? len_t'(LEN_MAX) : len_t'(n);
      r.saturated = sat;
      length_q.push_back(r);
      scanning   = 1'b0;
      pending_op = CH_NONE;
    endfunction

    function bit two_char_op(char_t first, char_t second);
      bit hit;
      hit = 1'b0;
      case (first)
        CH_STAR, CH_LT, CH_GT, CH_EQ, CH_BANG: hit = (second == CH_EQ);
        CH_AMP:   hit = (second == CH_AMP);
        CH_PLUS:  hit = (second == CH_EQ) || (second == CH_PLUS);
        CH_MINUS: hit = (second == CH_EQ) || (second == CH_MINUS);
        CH_SLASH: hit = (second == CH_SLASH) || (second == CH_EQ);
        default:  hit = 1'b0;
      endcase
      return hit;
    endfunction

    function bit punct_char(char_t c);
      return c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON ||
             c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
             c == CH_RBRACK || c == CH_CARET  || c == CH_PCT    ||
             c == CH_COMMA;
    endfunction

    function bit op_lead(char_t c);
      return c == CH_STAR || c == CH_LT || c == CH_GT || c == CH_EQ ||
             c == CH_BANG || c == CH_AMP || c == CH_PLUS ||
             c == CH_MINUS || c == CH_SLASH;
    endfunction

    // Applies one accepted character; returns 1 if a scan consumed it.
    function bit note_char(bit start_bit, char_t c);
      bit is_digit;
      if (start_bit) begin
        scanning    = 1'b1;
        count       = '0;
        overflow    = 1'b0;
        seen_dot    = 1'b0;
        digits_only = 1'b1;
        pending_op  = CH_NONE;
      end
      if (!scanning) return 1'b0;

      if (pending_op != CH_NONE) begin
        close_token(two_char_op(pending_op, c) ? 2 : 1, 1'b0);
        return 1'b1;
      end

      if (c == CH_DOT) seen_dot = 1'b1;

      if (c == CH_F && count > 1 && seen_dot && digits_only) begin
        bump();
        close_token(count, overflow);
        return 1'b1;
      end

      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (!is_digit && c != CH_DOT) digits_only = 1'b0;

      if (keep_blanks && (c == CH_TAB || c == CH_SPACE)) begin
        close_token((count == 0) ? 1 : count, overflow);
      end else if (c <= CH_SPACE || c >= CH_HIGH || c == CH_SEMI) begin
        close_token(count, overflow);
      end else if (punct_char(c)) begin
        close_token((count == 0) ? 1 : count, overflow);
      end else if (op_lead(c)) begin
        if (count == 0) pending_op = c;
        else close_token(count, overflow);
      end else if (c == CH_DOT && count == 0) begin
        close_token(1, 1'b0);
      end else if (c == CH_DOT && !digits_only) begin
        close_token(count, overflow);
      end else begin
        bump();
      end
      return 1'b1;
    endfunction

    function void check_result(len_t got_len, logic got_sat);
      token_len_t want;
      if (length_q.size() == 0) begin
        $display("%0t: unexpected result beat, got length=%0d saturated=%0b",
                 $time, got_len, got_sat);
        errors++;
        return;
      end
      want = length_q.pop_front();
      if (got_len !== want.length) begin
        $display("%0t: token_length mismatch, expected %0d, got %0d",
                 $time, want.length, got_len);
        errors++;
      end
      if (got_sat !== want.saturated) begin
        $display("%0t: length_saturated mismatch, expected %0b, got %0b",
                 $time, want.saturated, got_sat);
        errors++;
      end
    endfunction
  endclass

  localparam int PHASE_ITEMS = 220;  // four random phases after the long tokens

  logic clk = 1'b0;
  logic rst_n;

  tls_in_if  in_ch();
  tls_out_if out_ch();
  tls_cfg_if cfg_ch();

  token_length_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  token_scoreboard sb = new();

  int unsigned burst_left = 0;  // beats left in the current sender burst
  int unsigned used_items = 0;  // characters that an active scan consumed
  bit          hold_req   = 1'b0;  // asks the receiver for one long hold-off

  char_t punct_set[10] = '{CH_LBRACE, CH_RBRACE, CH_COLON, CH_LPAREN, CH_RPAREN,
                           CH_LBRACK, CH_RBRACK, CH_CARET, CH_PCT, CH_COMMA};
  char_t op_set[9]     = '{CH_STAR, CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP,
                           CH_PLUS, CH_MINUS, CH_SLASH};

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Character pickers
  // --------------------------------------------------------------------------
  function automatic char_t rand_digit();
    return CH_ZERO + char_t'($urandom_range(0, 9));
  endfunction

  // Letters and underscore; 'f' shows up like any other letter.
  function automatic char_t rand_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return char_t'(8'h61 + r);
    if (r < 52) return char_t'(8'h41 + r - 26);
    return char_t'(8'h5F);
  endfunction

  function automatic char_t rand_word_char();
    return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
  endfunction

  // Anything that can end a plain token: control byte, ';', high byte,
  // punctuation, operator lead or a dot.
  function automatic char_t rand_stop_char();
    case ($urandom_range(0, 5))
      0:       return char_t'($urandom_range(0, 32));
      1:       return CH_SEMI;
      2:       return char_t'($urandom_range(128, 255));
      3:       return punct_set[$urandom_range(0, 9)];
      4:       return op_set[$urandom_range(0, 8)];
      default: return CH_DOT;
    endcase
  endfunction

  // Second half of an operator: mostly a legal partner, sometimes junk.
  function automatic char_t rand_op_tail();
    case ($urandom_range(0, 5))
      0:       return CH_EQ;
      1:       return CH_AMP;
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      4:       return CH_SLASH;
      default: return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One character beat. The sender runs in bursts; between bursts valid
  // drops for a random gap. Returns at the edge that accepted the beat.
  task automatic send_char(input bit start_bit, input char_t ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= start_bit;
    in_ch.character <= ch;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (sb.note_char(start_bit, ch)) used_items++;
  endtask

  task automatic write_keep_blanks(input bit value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.keep_blanks <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.keep_blanks = value;
  endtask

  // Ends any open scan with a start on a NUL byte (an empty token), then
  // drains every owed result so the block is idle for a register write.
  task automatic settle();
    send_char(1'b1, CH_NONE);
    in_ch.valid <= 1'b0;
    while (sb.length_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Long token for the saturation corner: n counted characters, either an
  // identifier closed by a stop char or a digit run closed as a float.
  task automatic send_long(input int unsigned n, input bit numeric);
    int unsigned i;
    send_char(1'b1, numeric ? rand_digit() : rand_letter());
    for (i = 1; i < n; i++) send_char(1'b0, numeric ? rand_digit() : rand_word_char());
    if (numeric) begin
      send_char(1'b0, CH_DOT);
      send_char(1'b0, CH_F);
    end else begin
      send_char(1'b0, CH_SEMI);
    end
  endtask

  // One random token. Most are well formed so the scan reaches its deeper
  // states; the rest abandon a scan, send noise or mix classes.
  task automatic send_token();
    int unsigned kind, n, i;
    kind = $urandom_range(0, 99);
    if (kind < 24) begin
      // identifier
      send_char(1'b1, rand_letter());
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) send_char(1'b0, rand_word_char());
      send_char(1'b0, rand_stop_char());
    end else if (kind < 44) begin
      // number, optional fraction, optional float suffix
      send_char(1'b1, rand_digit());
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) send_char(1'b0, rand_digit());
      if ($urandom_range(0, 2) != 0) begin
        send_char(1'b0, CH_DOT);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) send_char(1'b0, rand_digit());
      end
      if ($urandom_range(0, 1) != 0) send_char(1'b0, CH_F);
      send_char(1'b0, rand_stop_char());
    end else if (kind < 58) begin
      // operator with lookahead
      send_char(1'b1, op_set[$urandom_range(0, 8)]);
      send_char(1'b0, rand_op_tail());
    end else if (kind < 66) begin
      // lone punctuation, dot or blank
      case ($urandom_range(0, 3))
        0:       send_char(1'b1, punct_set[$urandom_range(0, 9)]);
        1:       send_char(1'b1, CH_DOT);
        2:       send_char(1'b1, CH_TAB);
        default: send_char(1'b1, CH_SPACE);
      endcase
    end else if (kind < 72) begin
      // stop character first; an operator lead stays pending instead of ending
      send_char(1'b1, rand_stop_char());
    end else if (kind < 82) begin
      // scan dropped by the next start
      send_char(1'b1, rand_word_char());
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) send_char(1'b0, rand_word_char());
    end else if (kind < 92) begin
      // noise, mostly outside any scan
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++)
        send_char($urandom_range(0, 7) == 0, char_t'($urandom_range(0, 255)));
    end else if (kind < 98) begin
      // digits broken by a letter, then dot and suffix
      send_char(1'b1, rand_digit());
      send_char(1'b0, rand_letter());
      send_char(1'b0, CH_DOT);
      send_char(1'b0, CH_F);
      send_char(1'b0, rand_stop_char());
    end else begin
      send_long($urandom_range(240, 300), $urandom_range(0, 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: free runs, choppy stretches and rare long hold-offs. The hold
  // is counted here so the sender keeps offering and the block backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode, n, i;
    forever begin
      mode = $urandom_range(0, 99);
      if (hold_req || mode < 2) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(60, 120)) @(posedge clk);
      end else if (mode < 45) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        n = $urandom_range(4, 40);
        for (i = 0; i < n; i++) begin
          out_ch.ready <= ($urandom_range(0, 2) != 0);
          @(posedge clk);
        end
      end
    end
  end

  // Result monitor: values read right after the edge are the ones the
  // flops saw, so acceptance here matches the block's own view.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.token_length, out_ch.length_saturated);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    bit          blanks;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.start_req    <= 1'b0;
    in_ch.character    <= CH_NONE;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.keep_blanks <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_keep_blanks(1'b0);

    // Directed: blanks end tokens.
    send_char(1'b0, "a");                 // no scan yet, dropped
    send_char(1'b1, "a");                 // plain word ended by NUL
    send_char(1'b0, "b");
    send_char(1'b0, CH_NONE);
    send_char(1'b1, "1");                 // float with suffix keeps the 'f'
    send_char(1'b0, CH_DOT);
    send_char(1'b0, "5");
    send_char(1'b0, CH_F);
    send_char(1'b1, CH_LT);               // matched pair
    send_char(1'b0, CH_EQ);
    send_char(1'b1, CH_PLUS);             // unmatched pair gives 1
    send_char(1'b0, "x");
    send_char(1'b1, CH_LBRACE);           // lone punctuation
    send_char(1'b1, 8'hFF);               // high byte, empty token
    send_char(1'b1, CH_DOT);              // dot opening a token
    send_char(1'b1, "a");                 // dot after a letter ends it
    send_char(1'b0, CH_DOT);
    send_char(1'b1, "a");                 // operator after a word ends it
    send_char(1'b0, CH_EQ);
    send_char(1'b1, "x");                 // restart drops the open scan
    send_char(1'b1, "y");
    send_char(1'b0, CH_SEMI);
    send_char(1'b1, CH_EQ);               // restart drops a pending operator
    send_char(1'b1, "z");
    send_char(1'b0, CH_SPACE);
    send_char(1'b1, CH_SPACE);            // blank as end byte
    settle();

    // Directed: blanks end tokens, or are one-character tokens by themselves.
    write_keep_blanks(1'b1);
    send_char(1'b1, CH_TAB);
    send_char(1'b1, "a");
    send_char(1'b0, CH_SPACE);
    send_char(1'b1, CH_SPACE);

    // Random part. The first two tokens sit right at and beyond the length
    // cap; after them the receiver takes its long hold-off while short
    // tokens keep coming.
    send_long(MAX_TOKEN_LENGTH, 1'b0);
    send_long(MAX_TOKEN_LENGTH + 4, 1'b1);
    used_items = 0;
    hold_req   = 1'b1;

    blanks = 1'b1;
    for (phase = 1; phase <= 4; phase++) begin
      while (used_items < phase * PHASE_ITEMS) send_token();
      settle();
      if (phase < 4) begin
        blanks = !blanks;
        write_keep_blanks(blanks);
      end
    end

    if (sb.length_q.size() != 0 || sb.errors != 0) begin
      if (sb.length_q.size() != 0)
        $display("%0t: %0d token results never arrived", $time, sb.length_q.size());
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule
